@@ rtl/plane_depth_from_triangle_defines.svh @@
// Assertion helpers used by plane_depth_from_triangle
`ifndef PLANE_DEPTH_FROM_TRIANGLE_DEFINES_SVH
`define PLANE_DEPTH_FROM_TRIANGLE_DEFINES_SVH

// plain clocked check
`define PDT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// clocked implication
`define PDT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/pdt_pkg.sv @@
package pdt_pkg;

  localparam int CW   = 24;            // coordinate width
  localparam int DW   = CW + 1;        // vertex difference
  localparam int PW   = 2 * DW;        // difference product
  localparam int NW   = PW + 1;        // normal component
  localparam int NLO  = (NW + 1) / 2;  // low split of normal for multiply
  localparam int NHI  = NW - NLO;
  localparam int NUMW = NW + DW + 1;   // numerator
  localparam int QW   = CW + 2;        // quotient bits resolved by the cell chain
  localparam int EW   = QW + 2;        // depth before clipping

  typedef struct packed {
    logic [NUMW-1:0]     rem;
    logic [NUMW-1:0]     dsh;
    logic [QW-1:0]       quo;
    logic                neg;
    logic                big;
    logic                degen;
    logic signed [CW-1:0] z;
  } pdt_cell_t;

endpackage

@@ rtl/plane_depth_from_triangle.sv @@
// Pipeline: 7 front stages for normal and numerator, one divider cell per
//   quotient bit (26), one output register.
// Throughput: one beat per cycle; the whole pipeline advances unless a result
//   is held by out_stall.
// Reset: synchronous, clears all valid bits; payload registers are not reset.
module plane_depth_from_triangle
  import pdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] v1_x,
  input  logic signed [CW-1:0] v1_y,
  input  logic signed [CW-1:0] v1_z,
  input  logic signed [CW-1:0] v2_x,
  input  logic signed [CW-1:0] v2_y,
  input  logic signed [CW-1:0] v2_z,
  input  logic signed [CW-1:0] v3_x,
  input  logic signed [CW-1:0] v3_y,
  input  logic signed [CW-1:0] v3_z,
  input  logic signed [CW-1:0] point_x,
  input  logic signed [CW-1:0] point_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] depth,
  output logic                 degenerate,
  output logic                 saturated
);

`include "plane_depth_from_triangle_defines.svh"

  localparam logic signed [EW-1:0] MAXV = EW'((1 << (CW - 1)) - 1);
  localparam logic signed [EW-1:0] MINV = -EW'(1 << (CW - 1));

  logic en;
  logic [6:1] v;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: differences
  logic signed [DW-1:0] ax, ay, az, bx, by, bz, dx1, dy1;
  logic signed [CW-1:0] z1;
  // stage 2: products
  logic signed [PW-1:0] p_aybz, p_azby, p_azbx, p_axbz, p_axby, p_aybx;
  logic signed [DW-1:0] dx2, dy2;
  logic signed [CW-1:0] z2;
  // stage 3: normal
  logic signed [NW-1:0] nx, ny, nz3;
  logic signed [DW-1:0] dx3, dy3;
  logic signed [CW-1:0] z3;
  // stage 4: split products
  logic signed [NLO+DW:0]   pxl, pyl;
  logic signed [NHI+DW-1:0] pxh, pyh;
  logic signed [NW-1:0]     nz4;
  logic signed [CW-1:0]     z4;
  // stage 5/6
  logic signed [NUMW-1:0] px, py, num;
  logic signed [NW-1:0]   nz5, nz6;
  logic signed [CW-1:0]   z5, z6;

  logic [NUMW-1:0] rabs, dabs;
  pdt_cell_t       head;

  always_comb begin
    rabs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
    dabs = nz6[NW-1] ? NUMW'(-nz6) : NUMW'(nz6);
    head.rem   = rabs;
    head.dsh   = dabs << (QW - 1);
    head.quo   = '0;
    head.neg   = num[NUMW-1] ^ nz6[NW-1];
    head.big   = rabs >= (dabs << QW);
    head.degen = (nz6 == '0);
    head.z     = z6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= DW'(v1_x) - DW'(v2_x);
      ay  <= DW'(v1_y) - DW'(v2_y);
      az  <= DW'(v1_z) - DW'(v2_z);
      bx  <= DW'(v1_x) - DW'(v3_x);
      by  <= DW'(v1_y) - DW'(v3_y);
      bz  <= DW'(v1_z) - DW'(v3_z);
      dx1 <= DW'(point_x) - DW'(v1_x);
      dy1 <= DW'(point_y) - DW'(v1_y);
      z1  <= v1_z;

      p_aybz <= ay * bz;
      p_azby <= az * by;
      p_azbx <= az * bx;
      p_axbz <= ax * bz;
      p_axby <= ax * by;
      p_aybx <= ay * bx;
      dx2 <= dx1;
      dy2 <= dy1;
      z2  <= z1;

      nx  <= NW'(p_aybz) - NW'(p_azby);
      ny  <= NW'(p_azbx) - NW'(p_axbz);
      nz3 <= NW'(p_axby) - NW'(p_aybx);
      dx3 <= dx2;
      dy3 <= dy2;
      z3  <= z2;

      pxl <= $signed({1'b0, nx[NLO-1:0]}) * dx3;
      pyl <= $signed({1'b0, ny[NLO-1:0]}) * dy3;
      pxh <= $signed(nx[NW-1:NLO]) * dx3;
      pyh <= $signed(ny[NW-1:NLO]) * dy3;
      nz4 <= nz3;
      z4  <= z3;

      px  <= (NUMW'(pxh) <<< NLO) + NUMW'(pxl);
      py  <= (NUMW'(pyh) <<< NLO) + NUMW'(pyl);
      nz5 <= nz4;
      z5  <= z4;

      num <= px + py;
      nz6 <= nz5;
      z6  <= z5;
    end
  end

  pdt_cell_t     cd [QW+1];
  logic [QW:0]   cv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (en) begin
      cv[0] <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cd[0] <= head;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_cell
    pdt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_vld  (cv[i]),
      .in_data (cd[i]),
      .out_vld (cv[i+1]),
      .out_data(cd[i+1])
    );
  end

  // final subtract and clip
  pdt_cell_t            tl;
  logic signed [EW-1:0] qs, dfull;
  logic signed [CW-1:0] depth_next;
  logic                 sat_next;

  always_comb begin
    tl = cd[QW];
    qs = $signed({2'b00, tl.quo});
    dfull = EW'(tl.z) - (tl.neg ? -qs : qs);
    depth_next = dfull[CW-1:0];
    sat_next = 1'b0;
    priority if (tl.degen) begin
      depth_next = '0;
    end else if (tl.big) begin
      sat_next = 1'b1;
      depth_next = tl.neg ? MAXV[CW-1:0] : MINV[CW-1:0];
    end else if (dfull > MAXV) begin
      sat_next = 1'b1;
      depth_next = MAXV[CW-1:0];
    end else if (dfull < MINV) begin
      sat_next = 1'b1;
      depth_next = MINV[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth      <= depth_next;
      degenerate <= tl.degen;
      saturated  <= sat_next;
    end
  end

  `PDT_ASSERT_IMP(a_degen_zero, out_valid && degenerate, depth == '0 && !saturated, "degenerate beat with nonzero depth")
  `PDT_ASSERT_IMP(a_sat_rail, out_valid && saturated, depth == MAXV[CW-1:0] || depth == MINV[CW-1:0], "saturated beat off the rails")

endmodule

@@ rtl/pdt_cell.sv @@
module pdt_cell
  import pdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_vld,
  input  pdt_cell_t in_data,
  output logic      out_vld,
  output pdt_cell_t out_data
);

  logic      ge;
  pdt_cell_t nxt;

  always_comb begin
    ge = (in_data.rem >= in_data.dsh);
    nxt = in_data;
    nxt.rem = ge ? (in_data.rem - in_data.dsh) : in_data.rem;
    nxt.dsh = in_data.dsh >> 1;
    nxt.quo = {in_data.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule
